/* rtl/core/ipfix_stl_pkg.sv */
// Shared types, constants and helpers for the subTemplateList parser.
// Used by the front, command queue, back and top-level modules; no dependencies.
`timescale 1ns / 1ps

package ipfix_stl_pkg;

  localparam logic [7:0]  LONG_LEN_MARK = 8'd255;
  localparam logic [4:0]  REC_V4        = 5'd9;
  localparam logic [4:0]  REC_V6        = 5'd21;
  localparam logic [15:0] HDR_BYTES     = 16'd3;
  localparam logic [15:0] TPL_FIRST     = 16'd901;
  localparam logic [15:0] TPL_LAST      = 16'd904;

  localparam logic [1:0] KIND_RULE  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_LEN   = 3'd1;
  localparam logic [2:0] ERR_HDR_TRUNC = 3'd2;
  localparam logic [2:0] ERR_BAD_ID    = 3'd3;
  localparam logic [2:0] ERR_TOO_SMALL = 3'd4;

  localparam logic [1:0] FIELD_IFACE  = 2'd0;
  localparam logic [1:0] FIELD_PREFIX = 2'd1;
  localparam logic [1:0] FIELD_PLEN   = 2'd2;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        list_start;
    logic [15:0] buffer_length;
    logic [7:0]  check_mode;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [2:0]  error_code;
    logic [31:0] iface_id;
    logic [63:0] prefix_high;
    logic [63:0] prefix_low;
    logic [7:0]  prefix_length;
    logic [1:0]  template_index;
    logic [7:0]  rule_mode;
    logic        last_rule;
  } out_item_t;

  // One unit of work handed from the front to the back.
  typedef struct packed {
    logic        is_status;
    logic [1:0]  kind;
    logic [2:0]  err;
    logic [1:0]  field;
    logic        first;
    logic        emit;
    logic        last;
    logic [1:0]  tidx;
    logic [7:0]  mode;
    logic [7:0]  data;
  } cmd_t;

  function automatic logic [4:0] rec_size(input logic [1:0] sel);
    rec_size = sel[0] ? REC_V6 : REC_V4;
  endfunction

  function automatic logic [1:0] field_of(input logic [1:0] sel, input logic [4:0] idx);
    logic [1:0] f;
    f = FIELD_IFACE;
    case (sel)
      2'd0: f = (idx < 5'd4) ? FIELD_IFACE : ((idx < 5'd8) ? FIELD_PREFIX : FIELD_PLEN);
      2'd1: f = (idx < 5'd4) ? FIELD_IFACE : ((idx < 5'd20) ? FIELD_PREFIX : FIELD_PLEN);
      2'd2: f = (idx < 5'd4) ? FIELD_PREFIX : ((idx == 5'd4) ? FIELD_PLEN : FIELD_IFACE);
      default: f = (idx < 5'd16) ? FIELD_PREFIX : ((idx == 5'd16) ? FIELD_PLEN : FIELD_IFACE);
    endcase
    return f;
  endfunction

endpackage

/* rtl/core/ipfix_stl_front.sv */
// Front end: tracks the list header phases per byte and issues commands.
// Depends on ipfix_stl_pkg.
`timescale 1ns / 1ps

module ipfix_stl_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  ipfix_stl_pkg::in_item_t item,
  output logic                   cmd_push,
  output ipfix_stl_pkg::cmd_t    cmd
);

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_LEN_HI   = 3'd1;
  localparam logic [2:0] PH_LEN_LO   = 3'd2;
  localparam logic [2:0] PH_SEMANTIC = 3'd3;
  localparam logic [2:0] PH_ID_HI    = 3'd4;
  localparam logic [2:0] PH_ID_LO    = 3'd5;
  localparam logic [2:0] PH_RECORD   = 3'd6;

  logic [2:0]  phase, phase_next;
  logic [15:0] buffer_left, buffer_left_next;
  logic [15:0] list_left, list_left_next;
  logic [7:0]  hi_byte, hi_byte_next;
  logic [1:0]  layout, layout_next;
  logic [4:0]  rec_idx, rec_idx_next;
  logic [7:0]  mode, mode_next;

  logic [15:0] taken;
  logic [15:0] start_taken;
  logic [15:0] total;
  logic [15:0] id;
  logic [1:0]  id_off;
  logic [15:0] list_after_hdr;
  logic [15:0] list_dec;
  logic [4:0]  size;
  logic [4:0]  idx_inc;

  always_comb begin
    taken          = (buffer_left != 16'd0) ? buffer_left - 16'd1 : buffer_left;
    start_taken    = (item.buffer_length != 16'd0) ? item.buffer_length - 16'd1 : 16'd0;
    total          = {hi_byte, item.data_byte};
    id             = {hi_byte, item.data_byte};
    // Only the low two bits of the offset from the first ID select the layout.
    id_off         = id[1:0] - ipfix_stl_pkg::TPL_FIRST[1:0];
    list_after_hdr = list_left - ipfix_stl_pkg::HDR_BYTES;
    list_dec       = (list_left != 16'd0) ? list_left - 16'd1 : list_left;
    size           = ipfix_stl_pkg::rec_size(layout);
    idx_inc        = rec_idx + 5'd1;

    phase_next       = phase;
    buffer_left_next = buffer_left;
    list_left_next   = list_left;
    hi_byte_next     = hi_byte;
    layout_next      = layout;
    rec_idx_next     = rec_idx;
    mode_next        = mode;

    cmd_push      = 1'b0;
    cmd           = '0;
    cmd.data      = item.data_byte;
    cmd.mode      = mode;
    cmd.tidx      = layout;

    if (accept) begin
      if (item.list_start) begin
        mode_next        = item.check_mode;
        buffer_left_next = start_taken;
        rec_idx_next     = 5'd0;
        if (item.buffer_length == 16'd0) begin
          cmd_push   = 1'b1;
          cmd.is_status = 1'b1;
          cmd.kind   = ipfix_stl_pkg::KIND_ERROR;
          cmd.err    = ipfix_stl_pkg::ERR_BAD_LEN;
          phase_next = PH_IDLE;
        end else if (item.data_byte == ipfix_stl_pkg::LONG_LEN_MARK) begin
          if (start_taken < 16'd2) begin
            cmd_push   = 1'b1;
            cmd.is_status = 1'b1;
            cmd.kind   = ipfix_stl_pkg::KIND_ERROR;
            cmd.err    = ipfix_stl_pkg::ERR_BAD_LEN;
            phase_next = PH_IDLE;
          end else begin
            phase_next = PH_LEN_HI;
          end
        end else if (item.data_byte == 8'd0 || {8'd0, item.data_byte} > start_taken) begin
          cmd_push   = 1'b1;
          cmd.is_status = 1'b1;
          cmd.kind   = ipfix_stl_pkg::KIND_ERROR;
          cmd.err    = ipfix_stl_pkg::ERR_BAD_LEN;
          phase_next = PH_IDLE;
        end else begin
          list_left_next = {8'd0, item.data_byte};
          phase_next     = PH_SEMANTIC;
        end
      end else begin
        case (phase)
          PH_LEN_HI: begin
            hi_byte_next     = item.data_byte;
            buffer_left_next = taken;
            phase_next       = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            buffer_left_next = taken;
            if (total == 16'd0 || total > taken) begin
              cmd_push   = 1'b1;
              cmd.is_status = 1'b1;
              cmd.kind   = ipfix_stl_pkg::KIND_ERROR;
              cmd.err    = ipfix_stl_pkg::ERR_BAD_LEN;
              phase_next = PH_IDLE;
            end else begin
              list_left_next = total;
              phase_next     = PH_SEMANTIC;
            end
          end
          PH_SEMANTIC: begin
            buffer_left_next = taken;
            if (taken < 16'd2) begin
              cmd_push   = 1'b1;
              cmd.is_status = 1'b1;
              cmd.kind   = ipfix_stl_pkg::KIND_ERROR;
              cmd.err    = ipfix_stl_pkg::ERR_HDR_TRUNC;
              phase_next = PH_IDLE;
            end else begin
              phase_next = PH_ID_HI;
            end
          end
          PH_ID_HI: begin
            hi_byte_next     = item.data_byte;
            buffer_left_next = taken;
            phase_next       = PH_ID_LO;
          end
          PH_ID_LO: begin
            buffer_left_next = taken;
            if (!(id inside {[ipfix_stl_pkg::TPL_FIRST:ipfix_stl_pkg::TPL_LAST]})) begin
              cmd_push   = 1'b1;
              cmd.is_status = 1'b1;
              cmd.kind   = ipfix_stl_pkg::KIND_ERROR;
              cmd.err    = ipfix_stl_pkg::ERR_BAD_ID;
              phase_next = PH_IDLE;
            end else begin
              layout_next = id_off;
              if (list_left < ipfix_stl_pkg::HDR_BYTES) begin
                cmd_push   = 1'b1;
                cmd.is_status = 1'b1;
                cmd.kind   = ipfix_stl_pkg::KIND_ERROR;
                cmd.err    = ipfix_stl_pkg::ERR_TOO_SMALL;
                phase_next = PH_IDLE;
              end else begin
                list_left_next = list_after_hdr;
                if (list_after_hdr < {11'd0, ipfix_stl_pkg::rec_size(id_off)}) begin
                  cmd_push   = 1'b1;
                  cmd.is_status = 1'b1;
                  cmd.kind   = ipfix_stl_pkg::KIND_EMPTY;
                  cmd.err    = ipfix_stl_pkg::ERR_NONE;
                  phase_next = PH_IDLE;
                end else begin
                  rec_idx_next = 5'd0;
                  phase_next   = PH_RECORD;
                end
              end
            end
          end
          PH_RECORD: begin
            buffer_left_next = taken;
            list_left_next   = list_dec;
            cmd_push  = 1'b1;
            cmd.field = ipfix_stl_pkg::field_of(layout, rec_idx);
            cmd.first = (rec_idx == 5'd0);
            cmd.emit  = (idx_inc >= size);
            cmd.last  = (list_dec < {11'd0, size});
            if (idx_inc >= size) begin
              rec_idx_next = 5'd0;
              if (list_dec < {11'd0, size}) begin
                phase_next = PH_IDLE;
              end
            end else begin
              rec_idx_next = idx_inc;
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      buffer_left <= 16'd0;
      list_left   <= 16'd0;
      hi_byte     <= 8'd0;
      layout      <= 2'd0;
      rec_idx     <= 5'd0;
      mode        <= 8'd0;
    end else begin
      phase       <= phase_next;
      buffer_left <= buffer_left_next;
      list_left   <= list_left_next;
      hi_byte     <= hi_byte_next;
      layout      <= layout_next;
      rec_idx     <= rec_idx_next;
      mode        <= mode_next;
    end
  end

endmodule

/* rtl/core/ipfix_stl_cmdq.sv */
// Short command queue between the front and back ends.
// Depends on ipfix_stl_pkg.
`timescale 1ns / 1ps

module ipfix_stl_cmdq (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ipfix_stl_pkg::cmd_t push_cmd,
  output logic                full,
  input  logic                take,
  output logic                avail,
  output ipfix_stl_pkg::cmd_t head_cmd
);

  ipfix_stl_pkg::cmd_t slots [ipfix_stl_pkg::CMDQ_DEPTH];

  logic [ipfix_stl_pkg::CMDQ_AW-1:0] wr_ptr;
  logic [ipfix_stl_pkg::CMDQ_AW-1:0] rd_ptr;
  logic [ipfix_stl_pkg::CMDQ_AW:0]   count;
  logic                              do_push;
  logic                              do_take;

  assign full     = (count == (ipfix_stl_pkg::CMDQ_AW+1)'(ipfix_stl_pkg::CMDQ_DEPTH));
  assign avail    = (count != '0);
  assign head_cmd = slots[rd_ptr];
  assign do_push  = push && !full;
  assign do_take  = take && avail;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_take})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/core/ipfix_stl_back.sv */
// Back end: assembles record fields from commands and holds the result register.
// Depends on ipfix_stl_pkg.
`timescale 1ns / 1ps

module ipfix_stl_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cmd_avail,
  input  ipfix_stl_pkg::cmd_t      cmd,
  output logic                     cmd_take,
  output logic                     empty,
  input  logic                     pop,
  output ipfix_stl_pkg::out_item_t result
);

  logic [31:0] acc_iface;
  logic [63:0] acc_hi;
  logic [63:0] acc_lo;
  logic [7:0]  acc_plen;

  logic [31:0] iface_next;
  logic [63:0] hi_next;
  logic [63:0] lo_next;
  logic [7:0]  plen_next;

  logic                     out_valid;
  ipfix_stl_pkg::out_item_t out_reg;
  ipfix_stl_pkg::out_item_t out_next;
  logic                     slot_free;
  logic                     produces;

  assign slot_free = !out_valid || pop;
  assign produces  = cmd.is_status || cmd.emit;
  assign cmd_take  = cmd_avail && (!produces || slot_free);
  assign empty     = !out_valid;
  assign result    = out_reg;

  always_comb begin
    // The first byte of a record starts from cleared accumulators.
    iface_next = cmd.first ? 32'd0 : acc_iface;
    hi_next    = cmd.first ? 64'd0 : acc_hi;
    lo_next    = cmd.first ? 64'd0 : acc_lo;
    plen_next  = cmd.first ? 8'd0  : acc_plen;
    case (cmd.field)
      ipfix_stl_pkg::FIELD_IFACE: begin
        iface_next = {iface_next[23:0], cmd.data};
      end
      ipfix_stl_pkg::FIELD_PREFIX: begin
        hi_next = {hi_next[55:0], lo_next[63:56]};
        lo_next = {lo_next[55:0], cmd.data};
      end
      default: begin
        plen_next = cmd.data;
      end
    endcase
  end

  // Status results carry only the kind and the error code.
  always_comb begin
    out_next = '0;
    if (cmd.is_status) begin
      out_next.result_kind = cmd.kind;
      out_next.error_code  = cmd.err;
    end else begin
      out_next.result_kind    = ipfix_stl_pkg::KIND_RULE;
      out_next.error_code     = ipfix_stl_pkg::ERR_NONE;
      out_next.iface_id       = iface_next;
      out_next.prefix_high    = hi_next;
      out_next.prefix_low     = lo_next;
      out_next.prefix_length  = plen_next;
      out_next.template_index = cmd.tidx;
      out_next.rule_mode      = cmd.mode;
      out_next.last_rule      = cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take && !cmd.is_status) begin
      acc_iface <= iface_next;
      acc_hi    <= hi_next;
      acc_lo    <= lo_next;
      acc_plen  <= plen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take && produces) begin
      out_reg <= out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_take && produces) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* rtl/core/ipfix_subtemplate_list_parser.sv */
// Top level of the IPFIX subTemplateList parser: front, command queue and back.
// Depends on ipfix_stl_pkg, ipfix_stl_front, ipfix_stl_cmdq and ipfix_stl_back.
`timescale 1ns / 1ps

// The parser takes a subTemplateList one byte per item on the input queue
// (push/full). An item with list_start set opens a new list; its buffer_length
// and check_mode are sampled with that byte. Results leave through the
// output queue (empty/pop): one rule per complete record, marked last_rule on
// the final one, one "empty" result for a list with no whole record, or one
// error result carrying the error code.
//
// Throughput is one byte per cycle while the command queue is not full. The
// front tracks the header phases and issues one command per record byte or
// status event into a four-entry command queue; the back assembles the record
// fields and loads the result register. The command that completes a result
// goes into the command queue and loads the result register from its head.
//
// When the receiver stalls, the result register holds its item, the back
// stops draining commands that produce results, and full rises once the
// command queue fills; bytes that give no result still pass while the queue
// has room. Reset empties the queue and the result register and returns the
// front to idle, where bytes are ignored until a list start arrives.

module ipfix_subtemplate_list_parser (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  ipfix_stl_pkg::in_item_t  item,
  output logic                     empty,
  input  logic                     pop,
  output ipfix_stl_pkg::out_item_t result
);

  logic                accept;
  logic                cmd_push;
  ipfix_stl_pkg::cmd_t front_cmd;
  logic                cmd_take;
  logic                cmd_avail;
  ipfix_stl_pkg::cmd_t head_cmd;

  // An item is taken whenever the command queue has room, whether or not it
  // produces a command.
  assign accept = push && !full;

  ipfix_stl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .cmd_push (cmd_push),
    .cmd      (front_cmd)
  );

  ipfix_stl_cmdq u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_cmd (front_cmd),
    .full     (full),
    .take     (cmd_take),
    .avail    (cmd_avail),
    .head_cmd (head_cmd)
  );

  ipfix_stl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_avail (cmd_avail),
    .cmd       (head_cmd),
    .cmd_take  (cmd_take),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule
